### hw/rtl/lpcs_pkg.sv
// shared constants, types and helper functions for the lpc lattice speech synthesizer
`default_nettype none
package lpcs_pkg;

	localparam int CHIRP_LENGTH      = 52;
	localparam int COEFF_TABLE_DEPTH = 32;
	localparam int PITCH_TABLE_DEPTH = 64;
	localparam int ENERGY_DEPTH      = 16;
	localparam int CHIRP_DEPTH       = 64;
	localparam int NUM_K             = 10;

	// layout of the shared table memory
	localparam int ENERGY_BASE = 0;
	localparam int PITCH_BASE  = ENERGY_BASE + ENERGY_DEPTH;
	localparam int REFL_BASE   = PITCH_BASE + PITCH_TABLE_DEPTH;
	localparam int CHIRP_BASE  = REFL_BASE + NUM_K * COEFF_TABLE_DEPTH;
	localparam int TBL_ENTRIES = CHIRP_BASE + CHIRP_DEPTH;
	localparam int TBL_AW      = $clog2(TBL_ENTRIES);
	localparam int TBL_W       = 16;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_FRAME  = 2'd1,
		OP_TWRITE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [3:0] SEL_ENERGY = 4'd0;
	localparam logic [3:0] SEL_PITCH  = 4'd1;
	localparam logic [3:0] SEL_K1     = 4'd2;
	localparam logic [3:0] SEL_K10    = 4'd11;
	localparam logic [3:0] SEL_CHIRP  = 4'd12;

	localparam logic [3:0] GAIN_SILENT = 4'd0;
	localparam logic [3:0] GAIN_STOP   = 4'hf;

	localparam logic [15:0] LFSR_TAPS = 16'hb800;
	localparam logic [15:0] LFSR_SEED = 16'd1;
	localparam logic [9:0]  SPF_RESET = 10'd200;

	localparam int KPOS [NUM_K] = '{0, 5, 10, 14, 18, 22, 26, 30, 33, 36};
	localparam int KWID [NUM_K] = '{5, 5, 4, 4, 4, 4, 4, 3, 3, 3};

	// q4.15 lattice saturation
	function automatic logic signed [19:0] sat_lat(input logic signed [22:0] v);
		logic signed [19:0] r;
		if (v > 23'sd524287) begin
			r = 20'sd524287;
		end else if (v < -23'sd524288) begin
			r = -20'sd524288;
		end else begin
			r = v[19:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] clamp16(input logic signed [19:0] v);
		logic signed [15:0] r;
		if (v > 20'sd32767) begin
			r = 16'sd32767;
		end else if (v < -20'sd32768) begin
			r = -16'sd32768;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic [5:0] coeff_addr(input logic [38:0] p, input logic [3:0] k);
		logic [38:0] s;
		logic [38:0] m;
		if (int'(k) >= NUM_K) begin
			return 6'd0;
		end
		s = p >> KPOS[k];
		m = (39'd1 << KWID[k]) - 39'd1;
		return 6'(s & m);
	endfunction

endpackage
`default_nettype wire

### hw/rtl/lpcs_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module lpcs_ram #(
	parameter int W = 16,
	parameter int D = 512
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### hw/rtl/lpc_lattice_speech_synth.sv
// lpc lattice speech synthesizer top level with ten reflection stages
`default_nettype none
// Decode tables live in one block ram and are loaded by table-write words; the user
// must load them before any frame uses them, and the block itself does not enforce it.
// A silent or stop frame word is settled on acceptance; any other frame word then
// reads energy, pitch and ten coefficients from that ram. A tick word runs the lattice
// on a single shared 16x20 multiplier, each stage through forward, update, backward and
// backward-update steps: four stages unvoiced, and voiced a chirp fetch and scaling, the
// summed top stage pair and the other eight stages. The result sits in an output
// register, so the next word is taken while it waits.
module lpc_lattice_speech_synth (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// gain_index, pitch_index, repeat_frame, coeff_indices, table_select,
	// table_index, table_value, zero pad
	input  wire logic [79:0] s_tdata,
	// operation
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// sample
	output logic      [15:0] m_tdata,
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CHIRP = 9'b000000010,
		ST_EXC   = 9'b000000100,
		ST_FWD   = 9'b000001000,
		ST_UPD   = 9'b000010000,
		ST_BWD   = 9'b000100000,
		ST_BUPD  = 9'b001000000,
		ST_DONE  = 9'b010000000,
		ST_FRAME = 9'b100000000
	} state_t;

	state_t state_q;

	lpcs_pkg::op_t op;
	logic [3:0]  in_gain;
	logic [5:0]  in_pitch;
	logic        in_rep;
	logic [38:0] in_coeffs;
	logic [3:0]  in_tsel;
	logic [5:0]  in_tidx;
	logic [15:0] in_tval;
	logic        acc_in;

	assign op        = lpcs_pkg::op_t'(s_tuser);
	assign in_gain   = s_tdata[3:0];
	assign in_pitch  = s_tdata[9:4];
	assign in_rep    = s_tdata[10];
	assign in_coeffs = s_tdata[49:11];
	assign in_tsel   = s_tdata[53:50];
	assign in_tidx   = s_tdata[59:54];
	assign in_tval   = s_tdata[75:60];

	assign s_tready = (state_q == ST_IDLE);
	assign acc_in   = s_tvalid && s_tready;

	// configuration
	logic [9:0] spf_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {22'd0, spf_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spf_q <= lpcs_pkg::SPF_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			spf_q <= pwdata[9:0];
		end
	end

	// voice state
	logic signed [15:0] energy_q;
	logic        [7:0]  period_q;
	logic        [7:0]  pc_q;
	logic        [15:0] lfsr_q;
	logic        [9:0]  cnt_q;
	logic signed [15:0] c_q [lpcs_pkg::NUM_K];
	logic signed [19:0] x_q [lpcs_pkg::NUM_K];

	// frame word held during table reads
	logic [3:0]  gain_q;
	logic [5:0]  pitch_q;
	logic        rep_q;
	logic [38:0] coeffs_q;
	logic [3:0]  j_q;
	logic [3:0]  kk;
	assign kk = j_q - 4'd2;

	// tick datapath
	logic               chirp_ok_q;
	logic        [3:0]  i_q;
	logic signed [19:0] u_q;
	logic signed [36:0] acc_q;
	logic signed [35:0] prod_s1;

	// table ram
	logic                            tw_en;
	logic [lpcs_pkg::TBL_AW-1:0]     tw_addr;
	logic [lpcs_pkg::TBL_AW-1:0]     tr_addr;
	logic [lpcs_pkg::TBL_W-1:0]      tr_data;

	always_comb begin
		tw_en   = 1'b0;
		tw_addr = '0;
		priority if (in_tsel == lpcs_pkg::SEL_ENERGY) begin
			tw_en   = int'(in_tidx) < lpcs_pkg::ENERGY_DEPTH;
			tw_addr = lpcs_pkg::TBL_AW'(lpcs_pkg::ENERGY_BASE + int'(in_tidx));
		end else if (in_tsel == lpcs_pkg::SEL_PITCH) begin
			tw_en   = int'(in_tidx) < lpcs_pkg::PITCH_TABLE_DEPTH;
			tw_addr = lpcs_pkg::TBL_AW'(lpcs_pkg::PITCH_BASE + int'(in_tidx));
		end else if (in_tsel >= lpcs_pkg::SEL_K1 && in_tsel <= lpcs_pkg::SEL_K10) begin
			tw_en   = int'(in_tidx) < lpcs_pkg::COEFF_TABLE_DEPTH;
			tw_addr = lpcs_pkg::TBL_AW'(lpcs_pkg::REFL_BASE
				+ int'(in_tsel - lpcs_pkg::SEL_K1) * lpcs_pkg::COEFF_TABLE_DEPTH
				+ int'(in_tidx));
		end else if (in_tsel == lpcs_pkg::SEL_CHIRP) begin
			tw_en   = 1'b1;
			tw_addr = lpcs_pkg::TBL_AW'(lpcs_pkg::CHIRP_BASE + int'(in_tidx));
		end else begin
			tw_en = 1'b0;
		end
		tw_en = tw_en && acc_in && (op == lpcs_pkg::OP_TWRITE);
	end

	// pitch counter step for a voiced tick, noise lfsr step for an unvoiced one
	logic [7:0]  pc_new;
	logic [15:0] lfsr_new;
	assign pc_new   = (pc_q < period_q) ? pc_q + 8'd1 : 8'd0;
	assign lfsr_new = (lfsr_q >> 1) ^ (lfsr_q[0] ? lpcs_pkg::LFSR_TAPS : 16'd0);

	always_comb begin
		tr_addr = lpcs_pkg::TBL_AW'(lpcs_pkg::CHIRP_BASE + int'(pc_new[5:0]));
		if (state_q == ST_FRAME) begin
			priority if (j_q == 4'd0) begin
				tr_addr = lpcs_pkg::TBL_AW'(lpcs_pkg::ENERGY_BASE + int'(gain_q));
			end else if (j_q == 4'd1) begin
				tr_addr = lpcs_pkg::TBL_AW'(lpcs_pkg::PITCH_BASE + int'(pitch_q));
			end else begin
				tr_addr = lpcs_pkg::TBL_AW'(lpcs_pkg::REFL_BASE
					+ int'(kk) * lpcs_pkg::COEFF_TABLE_DEPTH
					+ int'(lpcs_pkg::coeff_addr(coeffs_q, kk)));
			end
		end
	end

	lpcs_ram #(
		.W(lpcs_pkg::TBL_W),
		.D(lpcs_pkg::TBL_ENTRIES)
	) u_tbl (
		.clk   (clk),
		.we    (tw_en),
		.waddr (tw_addr),
		.wdata (in_tval),
		.raddr (tr_addr),
		.rdata (tr_data)
	);

	// shared multiplier
	logic signed [15:0] mul_a;
	logic signed [19:0] mul_b;
	logic signed [35:0] mul_p;

	always_comb begin
		mul_a = c_q[i_q];
		mul_b = x_q[i_q];
		if (state_q == ST_CHIRP) begin
			mul_a = energy_q;
			mul_b = 20'(signed'(tr_data));
		end else if (state_q == ST_BWD) begin
			mul_b = u_q;
		end
	end
	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_s1 <= mul_p;
	end

	// lattice arithmetic
	logic signed [36:0] upd_sum;
	logic signed [22:0] upd_diff;
	logic signed [22:0] bupd_sum;
	logic signed [15:0] out_val;
	logic        [10:0] cnt_next;
	logic               last;

	assign upd_sum  = acc_q + 37'(prod_s1);
	assign upd_diff = 23'(u_q) - 23'(signed'(upd_sum[36:15]));
	assign bupd_sum = 23'(x_q[i_q]) + 23'(signed'(prod_s1[35:15]));
	assign out_val  = lpcs_pkg::clamp16(u_q);
	assign cnt_next = {1'b0, cnt_q} + 11'd1;
	assign last     = cnt_next >= {1'b0, spf_q};

	// frame ram data
	logic [5:0] fk_addr;
	assign fk_addr = lpcs_pkg::coeff_addr(coeffs_q, kk - 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			energy_q   <= '0;
			period_q   <= '0;
			pc_q       <= '0;
			lfsr_q     <= lpcs_pkg::LFSR_SEED;
			cnt_q      <= '0;
			c_q        <= '{default: '0};
			x_q        <= '{default: '0};
			gain_q     <= '0;
			pitch_q    <= '0;
			rep_q      <= 1'b0;
			coeffs_q   <= '0;
			j_q        <= '0;
			chirp_ok_q <= 1'b0;
			i_q        <= '0;
			u_q        <= '0;
			acc_q      <= '0;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			m_tlast    <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_DONE) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in && op == lpcs_pkg::OP_TICK) begin
						acc_q    <= '0;
						if (period_q != 8'd0) begin
							pc_q       <= pc_new;
							chirp_ok_q <= (int'(pc_new) < lpcs_pkg::CHIRP_LENGTH)
								&& (int'(pc_new) < lpcs_pkg::CHIRP_DEPTH);
							state_q    <= ST_CHIRP;
						end else begin
							lfsr_q  <= lfsr_new;
							u_q     <= lfsr_new[0] ? 20'(energy_q) : -20'(energy_q);
							i_q     <= 4'd3;
							state_q <= ST_FWD;
						end
					end else if (acc_in && op == lpcs_pkg::OP_FRAME) begin
						cnt_q <= '0;
						priority if (in_gain == lpcs_pkg::GAIN_SILENT) begin
							energy_q <= '0;
						end else if (in_gain == lpcs_pkg::GAIN_STOP) begin
							energy_q <= '0;
							period_q <= '0;
							c_q      <= '{default: '0};
							x_q      <= '{default: '0};
							lfsr_q   <= lpcs_pkg::LFSR_SEED;
							pc_q     <= '0;
						end else begin
							gain_q   <= in_gain;
							pitch_q  <= in_pitch;
							rep_q    <= in_rep;
							coeffs_q <= in_coeffs;
							j_q      <= '0;
							state_q  <= ST_FRAME;
						end
					end
				end
				ST_FRAME: begin
					// word j_q-1 of the frame comes back from the ram now
					if (j_q == 4'd1) begin
						energy_q <= signed'(tr_data);
					end else if (j_q == 4'd2) begin
						period_q <= (int'(pitch_q) < lpcs_pkg::PITCH_TABLE_DEPTH)
							? tr_data[7:0] : 8'd0;
					end else if (j_q >= 4'd3 && !rep_q
						&& (kk < 4'd5 || period_q != 8'd0)) begin
						c_q[kk - 4'd1] <= (int'(fk_addr) < lpcs_pkg::COEFF_TABLE_DEPTH)
							? signed'(tr_data) : 16'sd0;
					end
					if (j_q == 4'd12) begin
						state_q <= ST_IDLE;
					end else begin
						j_q <= j_q + 4'd1;
					end
				end
				ST_CHIRP: begin
					state_q <= ST_EXC;
				end
				ST_EXC: begin
					u_q     <= chirp_ok_q ? 20'(prod_s1[35:15]) : 20'sd0;
					i_q     <= 4'd9;
					state_q <= ST_FWD;
				end
				ST_FWD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					// top stage sums the k10 and k9 products before flooring
					if (i_q == 4'd9) begin
						acc_q   <= 37'(prod_s1);
						i_q     <= 4'd8;
						state_q <= ST_FWD;
					end else begin
						u_q     <= lpcs_pkg::sat_lat(upd_diff);
						acc_q   <= '0;
						state_q <= ST_BWD;
					end
				end
				ST_BWD: begin
					state_q <= ST_BUPD;
				end
				ST_BUPD: begin
					x_q[i_q + 4'd1] <= lpcs_pkg::sat_lat(bupd_sum);
					if (i_q == 4'd0) begin
						state_q <= ST_DONE;
					end else begin
						i_q     <= i_q - 4'd1;
						state_q <= ST_FWD;
					end
				end
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= out_val;
						m_tlast  <= last;
						x_q[0]   <= 20'(out_val);
						cnt_q    <= last ? 10'd0 : cnt_next[9:0];
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lpcs_chk.sv
// port-level checker for the lpc lattice speech synthesizer, bound to the top level
`default_nettype none
module lpcs_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic        psel,
	input wire logic        pready
);

	// a tick word always keeps the block busy for the next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == lpcs_pkg::OP_TICK |=> !s_tready)
		else $error("input ready right after a tick word");

	// a sample word appears only after the block was busy
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("output word without a busy cycle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output word changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("config port not ready");

endmodule

bind lpc_lattice_speech_synth lpcs_chk u_lpcs_chk (.*);
`default_nettype wire

### sim/lpcs_checker.sv
// checker for the lpc synthesizer: predicts every sample word and compares the output stream
`timescale 1ns / 100ps
`default_nettype none
module lpcs_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	// gain, pitch, repeat, coeff indices, table select, table index, table value
	input  wire logic [79:0] s_tdata,
	// operation
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	// sample
	input  wire logic [15:0] m_tdata,
	input  wire logic        m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               errors,
	output int               pending
);

	typedef struct {
		logic [15:0] smp;
		logic        last;
	} sample_exp_t;

	sample_exp_t sample_q [$];

	longint      energy_tab [lpcs_pkg::ENERGY_DEPTH];
	logic [7:0]  pitch_tab [lpcs_pkg::PITCH_TABLE_DEPTH];
	longint      refl_tab [lpcs_pkg::NUM_K * lpcs_pkg::COEFF_TABLE_DEPTH];
	longint      chirp_tab [lpcs_pkg::CHIRP_DEPTH];
	longint      energy;
	logic [7:0]  period;
	longint      kc [lpcs_pkg::NUM_K];
	longint      dly [lpcs_pkg::NUM_K];
	logic [15:0] lfsr;
	logic [7:0]  pcount;
	logic [9:0]  fcount;
	logic [9:0]  spf;

	function automatic longint sat20(input longint v);
		if (v > 524287) begin
			return 524287;
		end
		if (v < -524288) begin
			return -524288;
		end
		return v;
	endfunction

	function automatic void clear_voice();
		energy = 0;
		period = 0;
		for (int i = 0; i < lpcs_pkg::NUM_K; i++) begin
			kc[i] = 0;
			dly[i] = 0;
		end
		lfsr = lpcs_pkg::LFSR_SEED;
		pcount = 0;
		fcount = 0;
	endfunction

	function automatic void load_table(input logic [3:0] sel, input logic [5:0] idx,
			input logic [15:0] val);
		if (sel == lpcs_pkg::SEL_ENERGY) begin
			if (idx < lpcs_pkg::ENERGY_DEPTH) energy_tab[idx] = longint'($signed(val));
		end else if (sel == lpcs_pkg::SEL_PITCH) begin
			if (idx < lpcs_pkg::PITCH_TABLE_DEPTH) pitch_tab[idx] = val[7:0];
		end else if (sel >= lpcs_pkg::SEL_K1 && sel <= lpcs_pkg::SEL_K10) begin
			if (idx < lpcs_pkg::COEFF_TABLE_DEPTH)
				refl_tab[(sel - lpcs_pkg::SEL_K1) * lpcs_pkg::COEFF_TABLE_DEPTH + idx] =
					longint'($signed(val));
		end else if (sel == lpcs_pkg::SEL_CHIRP) begin
			chirp_tab[idx] = longint'($signed(val));
		end
	endfunction

	function automatic longint coeff_of(input logic [38:0] packed_k, input int k);
		int a;
		a = int'((packed_k >> lpcs_pkg::KPOS[k]) & ((39'd1 << lpcs_pkg::KWID[k]) - 39'd1));
		if (a >= lpcs_pkg::COEFF_TABLE_DEPTH) return 0;
		return refl_tab[k * lpcs_pkg::COEFF_TABLE_DEPTH + a];
	endfunction

	function automatic void start_frame(input logic [79:0] d);
		logic [3:0]  g;
		logic [5:0]  p;
		g = d[3:0];
		p = d[9:4];
		fcount = 0;
		if (g == lpcs_pkg::GAIN_SILENT) begin
			energy = 0;
		end else if (g == lpcs_pkg::GAIN_STOP) begin
			clear_voice();
		end else begin
			energy = energy_tab[g];
			period = (p < lpcs_pkg::PITCH_TABLE_DEPTH) ? pitch_tab[p] : 8'd0;
			if (!d[10]) begin
				for (int k = 0; k < 4; k++) kc[k] = coeff_of(d[49:11], k);
				if (period != 0)
					for (int k = 4; k < lpcs_pkg::NUM_K; k++) kc[k] = coeff_of(d[49:11], k);
			end
		end
	endfunction

	// one lattice sample, frame position marked
	function automatic sample_exp_t synth_tick();
		sample_exp_t e;
		longint      u;
		bit          voiced;
		logic [10:0] n;
		voiced = period != 0;
		if (voiced) begin
			if (pcount < period) pcount++;
			else pcount = 0;
			u = (pcount < lpcs_pkg::CHIRP_LENGTH) ? (chirp_tab[pcount] * energy) >>> 15 : 0;
		end else begin
			lfsr = (lfsr >> 1) ^ (lfsr[0] ? lpcs_pkg::LFSR_TAPS : 16'd0);
			u = lfsr[0] ? energy : -energy;
		end
		if (voiced) begin
			// last two stages share one rounding
			u = sat20(u - ((kc[9] * dly[9] + kc[8] * dly[8]) >>> 15));
			dly[9] = sat20(dly[8] + ((kc[8] * u) >>> 15));
			for (int i = 7; i >= 4; i--) begin
				u = sat20(u - ((kc[i] * dly[i]) >>> 15));
				dly[i + 1] = sat20(dly[i] + ((kc[i] * u) >>> 15));
			end
		end
		for (int i = 3; i >= 0; i--) begin
			u = sat20(u - ((kc[i] * dly[i]) >>> 15));
			dly[i + 1] = sat20(dly[i] + ((kc[i] * u) >>> 15));
		end
		if (u > 32767) u = 32767;
		if (u < -32768) u = -32768;
		dly[0] = u;
		n = fcount + 11'd1;
		e.last = n >= spf;
		fcount = e.last ? 10'd0 : n[9:0];
		e.smp = u[15:0];
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_exp_t got;
		sample_exp_t want;
		if (!arst_n) begin
			sample_q.delete();
			errors = 0;
			pending = 0;
			spf = lpcs_pkg::SPF_RESET;
			for (int i = 0; i < lpcs_pkg::ENERGY_DEPTH; i++) energy_tab[i] = 0;
			for (int i = 0; i < lpcs_pkg::PITCH_TABLE_DEPTH; i++) pitch_tab[i] = 0;
			for (int i = 0; i < lpcs_pkg::NUM_K * lpcs_pkg::COEFF_TABLE_DEPTH; i++)
				refl_tab[i] = 0;
			for (int i = 0; i < lpcs_pkg::CHIRP_DEPTH; i++) chirp_tab[i] = 0;
			clear_voice();
		end else begin
			if (psel && penable && pwrite && pready && paddr == 3'd0)
				spf = pwdata[9:0];
			if (s_tvalid && s_tready) begin
				case (lpcs_pkg::op_t'(s_tuser))
					lpcs_pkg::OP_TICK:   sample_q.insert(sample_q.size(), synth_tick());
					lpcs_pkg::OP_FRAME:  start_frame(s_tdata);
					lpcs_pkg::OP_TWRITE:
						load_table(s_tdata[53:50], s_tdata[59:54], s_tdata[75:60]);
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.smp = m_tdata;
				got.last = m_tlast;
				if (sample_q.size() == 0) begin
					$error("unexpected sample word %h last %b", got.smp, got.last);
					errors++;
				end else begin
					want = sample_q.pop_front();
					if (got.smp !== want.smp) begin
						$error("sample: expected %h actual %h", want.smp, got.smp);
						errors++;
					end
					if (got.last !== want.last) begin
						$error("last_of_frame: expected %b actual %b", want.last, got.last);
						errors++;
					end
				end
			end
			pending = sample_q.size();
		end
	end

endmodule
`default_nettype wire

### sim/lpc_lattice_speech_synth_test.sv
// stimulus and verdict for the lpc lattice speech synthesizer
`timescale 1ns / 100ps
`default_nettype none
module lpc_lattice_speech_synth_test;

	localparam longint CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// gain, pitch, repeat, coeff indices, table select, table index, table value, zero pad
	logic [79:0] s_tdata;
	// operation
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// sample
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;
	longint      cycles = 0;
	bit          calm;
	bit          hold_req;

	lpc_lattice_speech_synth u_top (.*);
	lpcs_checker u_check (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= calm || $urandom_range(99) >= 30;
		end
	end

	task automatic send_word(input lpcs_pkg::op_t op, input logic [3:0] gain,
			input logic [5:0] pitch, input logic rep, input logic [38:0] coeffs,
			input logic [3:0] tsel, input logic [5:0] tidx, input logic [15:0] tval);
		if (!calm && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'd0, tval, tidx, tsel, coeffs, rep, pitch, gain};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_tick();
		send_word(lpcs_pkg::OP_TICK, 4'($urandom), 6'($urandom), 1'($urandom),
			{7'($urandom), 32'($urandom)}, 4'($urandom), 6'($urandom), 16'($urandom));
	endtask

	task automatic send_frame(input logic [3:0] gain, input logic [5:0] pitch, input logic rep);
		send_word(lpcs_pkg::OP_FRAME, gain, pitch, rep, {7'($urandom), 32'($urandom)},
			4'($urandom), 6'($urandom), 16'($urandom));
	endtask

	task automatic write_entry(input logic [3:0] tsel, input logic [5:0] tidx,
			input logic [15:0] tval);
		send_word(lpcs_pkg::OP_TWRITE, 4'($urandom), 6'($urandom), 1'($urandom),
			{7'($urandom), 32'($urandom)}, tsel, tidx, tval);
	endtask

	function automatic logic [15:0] pick_value(input logic [3:0] tsel);
		logic [15:0] v;
		v = 16'($urandom);
		if (tsel == lpcs_pkg::SEL_PITCH) begin
			if ($urandom_range(99) < 30) v[7:0] = 8'd0;
			else v[7:0] = 8'($urandom_range(20, 160));
		end else if (tsel != lpcs_pkg::SEL_CHIRP && $urandom_range(1)) begin
			v = {{2{v[15]}}, v[15:2]};
		end
		return v;
	endfunction

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		// a frame word can still be in flight
		repeat (80) @(posedge clk);
	endtask

	task automatic reg_write(input logic [9:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'd0;
		pwdata <= {22'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int n);
		int          r;
		logic [3:0]  tsel;
		logic [3:0]  g;
		for (int i = 0; i < n; i++) begin
			calm = (i >= n / 3) && (i < n / 3 + 80);
			r = $urandom_range(99);
			if (r < 65) begin
				send_tick();
			end else if (r < 80) begin
				g = 4'($urandom_range(1, 14));
				if ($urandom_range(9) == 0) g = lpcs_pkg::GAIN_SILENT;
				if ($urandom_range(19) == 0) g = lpcs_pkg::GAIN_STOP;
				send_frame(g, 6'($urandom), $urandom_range(3) == 0);
			end else if (r < 95) begin
				tsel = 4'($urandom_range(0, 12));
				write_entry(tsel, 6'($urandom), pick_value(tsel));
			end else if (r < 98) begin
				write_entry(4'($urandom_range(13, 15)), 6'($urandom), 16'($urandom));
			end else begin
				send_word(lpcs_pkg::OP_NONE, 4'($urandom), 6'($urandom), 1'($urandom),
					{7'($urandom), 32'($urandom)}, 4'($urandom), 6'($urandom), 16'($urandom));
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		logic [9:0] spf_set [5];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = lpcs_pkg::OP_TICK;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		spf_set = '{10'd1, 10'd1023, 10'd0, 10'd7, 10'($urandom_range(2, 60))};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load every table entry so no frame reads an unwritten one
		for (int i = 0; i < lpcs_pkg::ENERGY_DEPTH; i++)
			write_entry(lpcs_pkg::SEL_ENERGY, 6'(i), pick_value(lpcs_pkg::SEL_ENERGY));
		write_entry(lpcs_pkg::SEL_PITCH, 6'd0, 16'd0);
		for (int i = 1; i < lpcs_pkg::PITCH_TABLE_DEPTH; i++)
			write_entry(lpcs_pkg::SEL_PITCH, 6'(i), pick_value(lpcs_pkg::SEL_PITCH));
		write_entry(lpcs_pkg::SEL_PITCH, 6'd63, 16'hff05);
		for (int k = 0; k < lpcs_pkg::NUM_K; k++)
			for (int i = 0; i < lpcs_pkg::COEFF_TABLE_DEPTH; i++)
				write_entry(lpcs_pkg::SEL_K1 + 4'(k), 6'(i),
					pick_value(lpcs_pkg::SEL_K1 + 4'(k)));
		for (int i = 0; i < lpcs_pkg::CHIRP_DEPTH; i++)
			write_entry(lpcs_pkg::SEL_CHIRP, 6'(i), pick_value(lpcs_pkg::SEL_CHIRP));

		// directed: extremes, ignored writes, silent, stop, repeat and voicing cases
		send_tick();
		write_entry(lpcs_pkg::SEL_ENERGY, 6'd14, 16'h7fff);
		write_entry(lpcs_pkg::SEL_ENERGY, 6'd40, 16'h8000);
		write_entry(lpcs_pkg::SEL_K1, 6'd50, 16'h7fff);
		write_entry(lpcs_pkg::SEL_K1, 6'd31, 16'h7fff);
		write_entry(4'd13, 6'd0, 16'h1234);
		write_entry(4'd15, 6'd63, 16'hffff);
		write_entry(lpcs_pkg::SEL_CHIRP, 6'd1, 16'h8000);
		send_word(lpcs_pkg::OP_NONE, 4'hf, 6'h3f, 1'b1, '1, 4'hf, 6'h3f, 16'hffff);
		send_frame(4'd14, 6'd63, 1'b0);
		repeat (4) send_tick();
		send_frame(4'd14, 6'd0, 1'b0);
		repeat (3) send_tick();
		send_frame(4'd14, 6'd63, 1'b1);
		repeat (2) send_tick();
		send_frame(lpcs_pkg::GAIN_SILENT, 6'd5, 1'b0);
		repeat (2) send_tick();
		send_frame(lpcs_pkg::GAIN_STOP, 6'd5, 1'b0);
		send_tick();
		send_frame(4'd1, 6'd63, 1'b0);

		// long receiver hold-off while ticks keep coming
		hold_req = 1'b1;
		repeat (40) send_tick();
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			reg_write(spf_set[ph]);
			random_phase(290);
			drain();
		end

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
